@@ hw/rtl/tte_pkg.sv @@
package tte_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int MAX_PLY_DEF    = 64;

  localparam int KEY_W   = 64;
  localparam int MOVE_W  = 16;
  localparam int SCORE_W = 16;
  localparam int DEPTH_W = 6;
  localparam int PLY_W   = 6;
  localparam int BOUND_W = 2;
  // ply-adjusted scores need two bits of headroom over the stored score
  localparam int ADJ_W   = 18;

  localparam int MATE_SCORE  = 30000;
  localparam int SCORE_CLAMP = 32000;

  typedef enum logic [0:0] {
    OP_PROBE = 1'b0,
    OP_STORE = 1'b1
  } op_t;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;
  // spare code: stored as given, never cuts
  localparam logic [BOUND_W-1:0] BOUND_SPARE = 2'd3;

  // input word, last field (key) in the lowest bits
  typedef struct packed {
    logic                pad;
    logic                is_pv;
    logic [SCORE_W-1:0]  beta;
    logic [SCORE_W-1:0]  alpha;
    logic [MOVE_W-1:0]   store_move;
    logic [BOUND_W-1:0]  bound_kind;
    logic [SCORE_W-1:0]  score;
    logic [DEPTH_W-1:0]  depth;
    logic [PLY_W-1:0]    ply;
    logic [KEY_W-1:0]    key;
  } in_word_t;

  // one table slot
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [MOVE_W-1:0]   move;
    logic [BOUND_W-1:0]  bound;
    logic [DEPTH_W-1:0]  depth;
    logic [SCORE_W-1:0]  score;
  } entry_t;

  typedef struct packed {
    logic [5:0]          pad;
    logic [SCORE_W-1:0]  cutoff_score;
    logic                cutoff;
    logic [MOVE_W-1:0]   hint_move;
    logic                hit;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

  localparam int IN_TDATA_W  = $bits(in_word_t);
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = $bits(out_word_t);
  localparam int ENTRY_W     = $bits(entry_t);

  // stored (ply-independent) score back to a search score
  function automatic logic signed [ADJ_W-1:0] to_search(
    input logic signed [ADJ_W-1:0] sc,
    input logic [PLY_W-1:0]         ply,
    input logic signed [ADJ_W-1:0] mate_bound
  );
    logic signed [ADJ_W-1:0] p;
    p = $signed({{(ADJ_W-PLY_W){1'b0}}, ply});
    if (sc >= mate_bound) begin
      to_search = sc - p;
    end else if (sc <= -mate_bound) begin
      to_search = sc + p;
    end else begin
      to_search = sc;
    end
  endfunction

  function automatic logic signed [ADJ_W-1:0] from_search(
    input logic signed [ADJ_W-1:0] sc,
    input logic [PLY_W-1:0]         ply,
    input logic signed [ADJ_W-1:0] mate_bound
  );
    logic signed [ADJ_W-1:0] p;
    p = $signed({{(ADJ_W-PLY_W){1'b0}}, ply});
    if (sc >= mate_bound) begin
      from_search = sc + p;
    end else if (sc <= -mate_bound) begin
      from_search = sc - p;
    end else begin
      from_search = sc;
    end
  endfunction

endpackage

@@ hw/rtl/tte_ram.sv @@
module tte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word when the same address is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/tte_slot_upd.sv @@
module tte_slot_upd #(
  parameter int INDEX_BITS = tte_pkg::INDEX_BITS_DEF,
  parameter int MAX_PLY    = tte_pkg::MAX_PLY_DEF
) (
  input  logic                   valid,
  input  tte_pkg::op_t           op,
  input  tte_pkg::in_word_t      item,
  input  logic                   table_en,
  input  tte_pkg::entry_t        entry,
  output logic                   wr_we,
  output logic [INDEX_BITS-1:0]  wr_idx,
  output tte_pkg::entry_t        wr_entry,
  output tte_pkg::res_t          res
);
  import tte_pkg::*;

  localparam logic signed [ADJ_W-1:0] MATE_BOUND = ADJ_W'(MATE_SCORE - MAX_PLY);
  localparam logic signed [ADJ_W-1:0] CLAMP_HI   = ADJ_W'(SCORE_CLAMP);
  localparam logic signed [ADJ_W-1:0] CLAMP_LO   = -CLAMP_HI;

  logic                    match;
  logic                    keep_slot;
  logic signed [ADJ_W-1:0] in_sc;
  logic signed [ADJ_W-1:0] st_sc;
  logic signed [ADJ_W-1:0] st_clamped;
  logic signed [ADJ_W-1:0] pr_sc;
  logic signed [ADJ_W-1:0] alpha_x;
  logic signed [ADJ_W-1:0] beta_x;
  logic                    hit;
  logic                    may_cut;
  logic                    cut;

  always_comb begin
    match     = entry.key == item.key;
    // a shallower non-exact result for the same position only refreshes the move
    keep_slot = match && (entry.depth > item.depth) && (item.bound_kind != BOUND_EXACT);

    in_sc = $signed({{(ADJ_W-SCORE_W){item.score[SCORE_W-1]}}, item.score});
    st_sc = from_search(in_sc, item.ply, MATE_BOUND);
    if (st_sc > CLAMP_HI) begin
      st_clamped = CLAMP_HI;
    end else if (st_sc < CLAMP_LO) begin
      st_clamped = CLAMP_LO;
    end else begin
      st_clamped = st_sc;
    end

    wr_idx   = item.key[INDEX_BITS-1:0];
    wr_we    = 1'b0;
    wr_entry = entry;
    if (valid && (op == OP_STORE) && table_en) begin
      if (keep_slot) begin
        wr_we         = item.store_move != '0;
        wr_entry.move = item.store_move;
      end else begin
        wr_we          = 1'b1;
        wr_entry.key   = item.key;
        wr_entry.move  = ((item.store_move == '0) && match) ? entry.move : item.store_move;
        wr_entry.bound = item.bound_kind;
        wr_entry.depth = item.depth;
        wr_entry.score = st_clamped[SCORE_W-1:0];
      end
    end

    pr_sc   = to_search($signed({{(ADJ_W-SCORE_W){entry.score[SCORE_W-1]}}, entry.score}),
                        item.ply, MATE_BOUND);
    alpha_x = $signed({{(ADJ_W-SCORE_W){item.alpha[SCORE_W-1]}}, item.alpha});
    beta_x  = $signed({{(ADJ_W-SCORE_W){item.beta[SCORE_W-1]}}, item.beta});
    hit     = table_en && match;
    may_cut = hit && !item.is_pv && (item.ply != '0) && (entry.depth >= item.depth);
    case (entry.bound)
      BOUND_EXACT: cut = may_cut;
      BOUND_LOWER: cut = may_cut && (pr_sc >= beta_x);
      BOUND_UPPER: cut = may_cut && (pr_sc <= alpha_x);
      default:     cut = 1'b0;
    endcase

    res.valid             = valid && (op == OP_PROBE);
    res.word.pad          = '0;
    res.word.hit          = hit;
    res.word.hint_move    = hit ? entry.move : '0;
    res.word.cutoff       = cut;
    res.word.cutoff_score = cut ? pr_sc[SCORE_W-1:0] : '0;
  end

endmodule

@@ hw/rtl/tte_out_queue.sv @@
module tte_out_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tte_pkg::res_t                      push,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tte_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [1:0]                         count
);
  import tte_pkg::*;

  out_word_t  q0_r, q0_nxt;
  out_word_t  q1_r, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  always_comb begin
    pop     = (cnt_r != 2'd0) && out_tready;
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    case ({push.valid, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          q0_nxt = push.word;
        end else begin
          q1_nxt = push.word;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        q0_nxt  = q1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          q0_nxt = push.word;
        end else begin
          q0_nxt = q1_r;
          q1_nxt = push.word;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata  = q0_r;
  assign count      = cnt_r;

endmodule

@@ hw/rtl/transposition_table_engine.sv @@
// channel   dir  handshake             payload
// in_       in   in_tvalid/in_tready   in_tdata: key, ply, depth, score, bound_kind,
//                                      store_move, alpha, beta, is_pv; in_tuser: op
// out_      out  out_tvalid/out_tready out_tdata: hit, hint_move, cutoff, cutoff_score
// cfg_      in   cfg_we                cfg_wdata: table_enable
//
// One word per cycle while in_tready is high: the slot is read at acceptance, updated
// and written back the next cycle through the single table memory; a write to the
// slot just read is forwarded. A probe's result passes the stage register into the
// output queue and is offered from there; a store gives none.
// After reset a sweep clears all 2**INDEX_BITS slots, one per cycle, with in_tready low.
// Results wait in a two-word queue; in_tready also drops when it could overflow.
module transposition_table_engine #(
  parameter int INDEX_BITS = tte_pkg::INDEX_BITS_DEF,
  parameter int MAX_PLY    = tte_pkg::MAX_PLY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // key, ply, depth, score, bound_kind, store_move, alpha, beta, is_pv, zero pad
  input  logic [tte_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op
  input  logic [tte_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit, hint_move, cutoff, cutoff_score, zero pad
  output logic [tte_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata
);
  import tte_pkg::*;

  localparam int DEPTH = 2 ** INDEX_BITS;

  in_word_t              in_word;
  logic                  in_acc;

  logic                  clr_busy_r, clr_busy_nxt;
  logic [INDEX_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic                  en_r, en_nxt;

  logic                  s1_valid_r;
  op_t                   s1_op_r;
  in_word_t              s1_item_r;
  logic                  fwd_hit_r;
  entry_t                fwd_data_r;

  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  entry_t                ram_wdata;
  logic [INDEX_BITS-1:0] ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                cur_entry;

  logic                  upd_we;
  logic [INDEX_BITS-1:0] upd_idx;
  entry_t                upd_entry;
  res_t                  upd_res;

  logic [1:0]            q_cnt;
  logic                  q_pop;
  logic                  s1_probe;

  assign in_word   = in_tdata;
  assign ram_raddr = in_word.key[INDEX_BITS-1:0];
  assign cur_entry = fwd_hit_r ? fwd_data_r : entry_t'(ram_rdata);

  // accept only when the queue has room for everything still on its way
  assign s1_probe  = s1_valid_r && (s1_op_r == OP_PROBE);
  assign q_pop     = (q_cnt != 2'd0) && out_tready;
  assign in_tready = !clr_busy_r &&
                     (({1'b0, q_cnt} + {2'b0, s1_probe}) <= (3'd1 + {2'b0, q_pop}));
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == {INDEX_BITS{1'b1}}) begin
        clr_busy_nxt = 1'b0;
      end
    end
    en_nxt = cfg_we ? cfg_wdata : en_r;

    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = upd_idx;
      ram_wdata = upd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      en_r       <= 1'b1;
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
      en_r       <= en_nxt;
      s1_valid_r <= in_acc;
      // the memory returns the old word when the slot is written as it is read
      fwd_hit_r  <= ram_we && (ram_waddr == ram_raddr);
    end
    s1_op_r    <= op_t'(in_tuser[0]);
    s1_item_r  <= in_word;
    fwd_data_r <= ram_wdata;
  end

  tte_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tte_slot_upd #(
    .INDEX_BITS (INDEX_BITS),
    .MAX_PLY    (MAX_PLY)
  ) u_upd (
    .valid    (s1_valid_r),
    .op       (s1_op_r),
    .item     (s1_item_r),
    .table_en (en_r),
    .entry    (cur_entry),
    .wr_we    (upd_we),
    .wr_idx   (upd_idx),
    .wr_entry (upd_entry),
    .res      (upd_res)
  );

  tte_out_queue u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (upd_res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .count      (q_cnt)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_acc)
    else $error("word accepted during clearing sweep");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_res.valid && (q_cnt == 2'd2)) |-> out_tready)
    else $error("result pushed into a full queue");

  a_cutoff_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    upd_res.valid |-> (!upd_res.word.cutoff || upd_res.word.hit))
    else $error("cutoff without hit");

  a_no_store_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_valid_r)
    else $error("table update during clearing sweep");

endmodule

@@ tb/tb_transposition_table_engine.sv @@
module tb_transposition_table_engine;
  import tte_pkg::*;

  localparam int MATE_EDGE = MATE_SCORE - MAX_PLY_DEF;
  localparam int SLOT_BITS = INDEX_BITS_DEF;

  typedef struct {
    op_t      op;
    in_word_t w;
  } tt_request_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic                   cfg_wdata = 1'b1;

  tt_request_t requests_to_send[$];
  out_word_t   probe_results_due[$];
  entry_t      shadow_slots[int unsigned];
  logic        shadow_enable = 1'b1;

  tt_request_t drv_item;
  logic        in_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          error_count = 0;
  int          result_count = 0;
  logic [63:0] key_pool[16];

  transposition_table_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("mismatch at result %0d: %s", result_count, msg);
    error_count++;
  endtask

  // shadow of the table: work out what one accepted word does
  task automatic apply_word(input op_t op, input in_word_t w);
    int unsigned             idx;
    entry_t                  slot;
    logic                    key_hit;
    logic signed [ADJ_W-1:0] sc;
    logic signed [ADJ_W-1:0] plyv;
    logic signed [ADJ_W-1:0] lo;
    logic signed [ADJ_W-1:0] hi;
    out_word_t               res;
    idx = 32'(w.key[SLOT_BITS-1:0]);
    slot = shadow_slots.exists(idx) ? shadow_slots[idx] : '0;
    key_hit = (slot.key == w.key);
    plyv = ADJ_W'(w.ply);
    if (op == OP_STORE) begin
      if (shadow_enable) begin
        if (key_hit && slot.depth > w.depth && w.bound_kind != BOUND_EXACT) begin
          // shallower bound: only a fresh move gets in
          if (w.store_move != '0) slot.move = w.store_move;
        end else begin
          if (!(w.store_move == '0 && key_hit)) slot.move = w.store_move;
          sc = ADJ_W'($signed(w.score));
          if (sc >= MATE_EDGE) sc = sc + plyv;
          else if (sc <= -MATE_EDGE) sc = sc - plyv;
          if (sc > SCORE_CLAMP) sc = ADJ_W'(SCORE_CLAMP);
          if (sc < -SCORE_CLAMP) sc = ADJ_W'(-SCORE_CLAMP);
          slot.key = w.key;
          slot.score = sc[SCORE_W-1:0];
          slot.depth = w.depth;
          slot.bound = w.bound_kind;
        end
        shadow_slots[idx] = slot;
      end
    end else begin
      res = '0;
      if (shadow_enable && key_hit) begin
        res.hit = 1'b1;
        res.hint_move = slot.move;
        if (!w.is_pv && w.ply != '0 && slot.depth >= w.depth) begin
          sc = ADJ_W'($signed(slot.score));
          if (sc >= MATE_EDGE) sc = sc - plyv;
          else if (sc <= -MATE_EDGE) sc = sc + plyv;
          lo = ADJ_W'($signed(w.alpha));
          hi = ADJ_W'($signed(w.beta));
          if (slot.bound == BOUND_EXACT || (slot.bound == BOUND_LOWER && sc >= hi) ||
              (slot.bound == BOUND_UPPER && sc <= lo)) begin
            res.cutoff = 1'b1;
            res.cutoff_score = sc[SCORE_W-1:0];
          end
        end
      end
      probe_results_due.push_back(res);
    end
  endtask

  task automatic push_word(input op_t op, input logic [63:0] key, input int ply,
                           input int depth, input logic [15:0] score,
                           input logic [BOUND_W-1:0] bound,
                           input logic [15:0] mv, input logic [15:0] alpha,
                           input logic [15:0] beta, input bit pv);
    tt_request_t r;
    r.op = op;
    r.w = '0;
    r.w.key = key;
    r.w.ply = PLY_W'(ply);
    r.w.depth = DEPTH_W'(depth);
    r.w.score = score;
    r.w.bound_kind = bound;
    r.w.store_move = mv;
    r.w.alpha = alpha;
    r.w.beta = beta;
    r.w.is_pv = pv;
    requests_to_send.push_back(r);
  endtask

  function automatic logic [15:0] rand_score();
    int r;
    int mag;
    r = $urandom_range(0, 99);
    if (r < 45) return 16'(int'($urandom_range(0, 62000)) - 31000);
    if (r < 75) begin
      mag = $urandom_range(29800, 31000);
      return $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
    end
    if (r < 85) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 8))
      0: return 16'(-31000);
      1: return 16'(31000);
      2: return 16'(MATE_EDGE);
      3: return 16'(-MATE_EDGE);
      4: return 16'(MATE_EDGE - 1);
      5: return 16'(1 - MATE_EDGE);
      6: return 16'h7FFF;
      7: return 16'h8000;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [63:0] rand_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 15)];
    return {$urandom, $urandom};
  endfunction

  function automatic int rand_depth();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12) : $urandom_range(0, 63);
  endfunction

  function automatic int rand_ply();
    return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 63);
  endfunction

  function automatic logic [BOUND_W-1:0] rand_bound();
    return ($urandom_range(0, 19) == 0) ? BOUND_SPARE : BOUND_W'($urandom_range(0, 2));
  endfunction

  function automatic logic [15:0] rand_move();
    return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [15:0] near_score(input logic [15:0] s);
    return 16'(int'($signed(s)) + int'($urandom_range(0, 40)) - 20);
  endfunction

  // mostly a store followed by probes of the same key, the rest loose words
  task automatic feed_random(input int n);
    int          count;
    int          reps;
    int          d;
    int          pl;
    logic [63:0] k;
    logic [15:0] s;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 99) < 70) begin
        k = rand_key();
        d = rand_depth();
        pl = rand_ply();
        s = rand_score();
        push_word(OP_STORE, k, pl, d, s, rand_bound(), rand_move(), rand_score(),
                  rand_score(), $urandom_range(0, 1));
        reps = $urandom_range(1, 3);
        repeat (reps) begin
          push_word(OP_PROBE, k, ($urandom_range(0, 4) == 0) ? rand_ply() : pl,
                    ($urandom_range(0, 7) == 0) ? d + 1 : $urandom_range(0, d),
                    rand_score(), rand_bound(), rand_move(), near_score(s), near_score(s),
                    $urandom_range(0, 4) == 0);
        end
        count += 1 + reps;
      end else begin
        push_word(op_t'($urandom_range(0, 1)), rand_key(), $urandom_range(0, 63),
                  rand_depth(), rand_score(), rand_bound(), rand_move(), rand_score(),
                  rand_score(), $urandom_range(0, 1));
        count++;
      end
    end
  endtask

  // wait until every word is in and every result is out, then let stores retire
  task automatic settle();
    while (requests_to_send.size() != 0 || in_tvalid || probe_results_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int items, input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    feed_random(items);
    settle();
  endtask

  // sender: advance on acceptance, otherwise hold the word
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item = requests_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= drv_item.w;
        in_tuser <= drv_item.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t got;
    out_word_t due;
    in_taken = in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_we) shadow_enable = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        result_count++;
        if (probe_results_due.size() == 0) begin
          flag_error("result word with nothing outstanding");
        end else begin
          due = probe_results_due.pop_front();
          if (got.hit !== due.hit)
            flag_error($sformatf("hit got %0b want %0b", got.hit, due.hit));
          if (got.hint_move !== due.hint_move)
            flag_error($sformatf("hint_move got %h want %h", got.hint_move, due.hint_move));
          if (got.cutoff !== due.cutoff)
            flag_error($sformatf("cutoff got %0b want %0b", got.cutoff, due.cutoff));
          if (got.cutoff_score !== due.cutoff_score)
            flag_error($sformatf("cutoff_score got %0d want %0d",
                                 $signed(got.cutoff_score), $signed(due.cutoff_score)));
          if (got.pad !== '0)
            flag_error($sformatf("pad bits got %b", got.pad));
        end
      end
      if (in_taken) apply_word(op_t'(in_tuser[0]), in_word_t'(in_tdata));
    end
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] kc;
    logic [63:0] kd;
    logic [63:0] ke;
    logic [63:0] kf;
    for (int i = 0; i < 10; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[10] = 64'd0;
    key_pool[11] = '1;
    // same slot, different key
    for (int i = 12; i < 16; i++) key_pool[i] = {$urandom, key_pool[i-12][31:0]};
    ka = 64'h0123_4567_89AB_0010;
    kb = 64'h1111_2222_3333_0020;
    kc = 64'h4444_5555_6666_0030;
    kd = 64'h7777_8888_9999_0040;
    ke = 64'hAAAA_BBBB_CCCC_0050;
    kf = '1;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    // hold off until the clearing sweep is done
    while (in_tready !== 1'b1) @(posedge clk);
    write_enable(1'b1);

    // cleared slot answers for key zero
    push_word(OP_PROBE, 64'd0, 5, 0, 16'd0, BOUND_EXACT, 16'd0, 16'd0, 16'd0, 1'b0);
    push_word(OP_PROBE, 64'd0, 0, 0, 16'd0, BOUND_EXACT, 16'd0, 16'd0, 16'd0, 1'b0);
    // mate score made ply-independent and back
    push_word(OP_STORE, ka, 10, 5, 16'd29950, BOUND_EXACT, 16'h1234, 16'd0, 16'd0, 1'b0);
    push_word(OP_PROBE, ka, 3, 5, 16'd0, BOUND_EXACT, 16'd0, 16'd0, 16'd0, 1'b0);
    // shallower bound: move kept without a new one, replaced with one
    push_word(OP_STORE, ka, 0, 2, 16'd5, BOUND_LOWER, 16'd0, 16'd0, 16'd0, 1'b0);
    push_word(OP_STORE, ka, 0, 2, 16'd5, BOUND_UPPER, 16'hBEEF, 16'd0, 16'd0, 1'b0);
    push_word(OP_PROBE, ka, 1, 6, 16'd0, BOUND_EXACT, 16'd0, 16'd0, 16'd0, 1'b0);
    push_word(OP_PROBE, ka, 1, 0, 16'd0, BOUND_EXACT, 16'd0, 16'd0, 16'd0, 1'b1);
    push_word(OP_STORE, kb, 4, 3, 16'd100, BOUND_LOWER, 16'd0, 16'd0, 16'd0, 1'b0);
    push_word(OP_PROBE, kb, 4, 3, 16'd0, BOUND_EXACT, 16'd0, 16'd0, 16'd100, 1'b0);
    push_word(OP_PROBE, kb, 4, 3, 16'd0, BOUND_EXACT, 16'd0, 16'd0, 16'd101, 1'b0);
    push_word(OP_STORE, kc, 7, 3, 16'(-500), BOUND_UPPER, 16'd77, 16'd0, 16'd0, 1'b0);
    push_word(OP_PROBE, kc, 7, 3, 16'd0, BOUND_EXACT, 16'd0, 16'(-500), 16'd0, 1'b0);
    push_word(OP_PROBE, kc, 7, 3, 16'd0, BOUND_EXACT, 16'd0, 16'(-501), 16'd0, 1'b0);
    // spare bound code never cuts
    push_word(OP_STORE, kd, 1, 63, 16'd0, BOUND_SPARE, 16'd9, 16'd0, 16'd0, 1'b0);
    push_word(OP_PROBE, kd, 1, 0, 16'd0, BOUND_EXACT, 16'd0, 16'(31000), 16'(-31000),
              1'b0);
    // out-of-range scores clamp
    push_word(OP_STORE, ke, 63, 4, 16'h8000, BOUND_EXACT, 16'd1, 16'd0, 16'd0, 1'b0);
    push_word(OP_PROBE, ke, 1, 4, 16'd0, BOUND_EXACT, 16'd0, 16'd0, 16'd0, 1'b0);
    push_word(OP_STORE, kf, 63, 63, 16'h7FFF, BOUND_EXACT, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1'b1);
    push_word(OP_PROBE, kf, 63, 63, 16'hFFFF, BOUND_SPARE, 16'hFFFF, 16'h7FFF, 16'h8000,
              1'b0);
    // collision evicts, then a store without a move leaves none
    push_word(OP_STORE, 64'hFEDC_0000_0000_0010, 2, 1, 16'd7, BOUND_EXACT, 16'd5, 16'd0,
              16'd0, 1'b0);
    push_word(OP_PROBE, ka, 2, 0, 16'd0, BOUND_EXACT, 16'd0, 16'd0, 16'd0, 1'b0);
    push_word(OP_STORE, ka, 2, 1, 16'd7, BOUND_LOWER, 16'd0, 16'd0, 16'd0, 1'b0);
    push_word(OP_PROBE, ka, 2, 1, 16'd0, BOUND_EXACT, 16'd0, 16'd0, 16'd7, 1'b0);
    settle();

    run_phase(450, 0, 0);
    run_phase(350, 83, 0);

    write_enable(1'b0);
    run_phase(100, 0, 0);
    write_enable(1'b1);
    // stores made while disabled must not show up
    run_phase(150, 14, 14);

    run_phase(350, 0, 83);

    hold_req++;
    run_phase(350, 14, 14);

    write_enable(1'b0);
    run_phase(40, 0, 0);
    write_enable(1'b1);
    run_phase(80, 0, 0);

    settle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tte_pkg.sv
hw/rtl/tte_ram.sv
hw/rtl/tte_slot_upd.sv
hw/rtl/tte_out_queue.sv
hw/rtl/transposition_table_engine.sv
tb/tb_transposition_table_engine.sv
